// ----- design/bpcr_pkg.sv -----
// ----------------------------------------------------------------------------
// Ball pair collision response: shared package
// Field widths, word layouts, pipeline sideband types and output saturation.
// ----------------------------------------------------------------------------
package bpcr_pkg;

  localparam int POS_W       = 32;  // signed fixed-point position or velocity
  localparam int RAD_W       = 31;  // unsigned radius
  localparam int ID_W        = 8;   // ball identifier
  localparam int DV_W        = 33;  // velocity difference
  localparam int MAG_W       = 31;  // normalized vector magnitude
  localparam int SH_W        = 2;   // normalizing shift count
  localparam int ROOT_W      = 32;  // square root result
  localparam int SQ_W        = 64;  // sum of squares and root working width
  localparam int IN_TDATA_W  = 336;
  localparam int OUT_TDATA_W = 192;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  // Input word, first field in the lowest bits.
  typedef struct packed {
    logic [1:0]              pad;
    logic [ID_W-1:0]         b_id;
    logic [RAD_W-1:0]        b_radius;
    logic signed [POS_W-1:0] b_vel_y;
    logic signed [POS_W-1:0] b_vel_x;
    logic signed [POS_W-1:0] b_pos_y;
    logic signed [POS_W-1:0] b_pos_x;
    logic [ID_W-1:0]         a_id;
    logic [RAD_W-1:0]        a_radius;
    logic signed [POS_W-1:0] a_vel_y;
    logic signed [POS_W-1:0] a_vel_x;
    logic signed [POS_W-1:0] a_pos_y;
    logic signed [POS_W-1:0] a_pos_x;
  } in_word_t;

  // Output word, first field in the lowest bits.
  typedef struct packed {
    logic [POS_W-1:0] new_pos_y;
    logic [POS_W-1:0] new_pos_x;
    logic [POS_W-1:0] msg_vel_y;
    logic [POS_W-1:0] msg_vel_x;
    logic [POS_W-1:0] new_vel_y;
    logic [POS_W-1:0] new_vel_x;
  } out_word_t;

  // Values carried alongside the root and divide pipelines.
  typedef struct packed {
    logic signed [DV_W-1:0]  dvx;
    logic signed [DV_W-1:0]  dvy;
    logic [POS_W-1:0]        rsum;
    logic                    idne;
    logic signed [POS_W-1:0] apx;
    logic signed [POS_W-1:0] apy;
    logic signed [POS_W-1:0] avx;
    logic signed [POS_W-1:0] avy;
    logic signed [POS_W-1:0] bvx;
    logic signed [POS_W-1:0] bvy;
    logic [MAG_W-1:0]        mx;
    logic [MAG_W-1:0]        my;
    logic [MAG_W-1:0]        cmx;
    logic [MAG_W-1:0]        cmy;
    logic                    nx;
    logic                    ny;
    logic                    cnx;
    logic                    cny;
    logic [SH_W-1:0]         s1;
    logic [SH_W-1:0]         s2;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [ROOT_W-1:0] q1;  // root for the predicted positions
    logic [ROOT_W-1:0] q2;  // root for the current positions
  } mid_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic [POS_W-1:0] sat32(input logic signed [63:0] v);
    logic [POS_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[POS_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/bpcr_isqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage over several lanes, with a sideband word and
// a per-stage valid that collapses bubbles under backpressure.
// ----------------------------------------------------------------------------
module bpcr_isqrt #(
  parameter int LANES = 2,
  parameter int SBW   = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bpcr_pkg::SQ_W-1:0]   in_rad_i [LANES],
  input  logic [SBW-1:0]              in_side_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bpcr_pkg::ROOT_W-1:0] out_root_o [LANES],
  output logic [SBW-1:0]              out_side_o
);

  localparam int NS = bpcr_pkg::ROOT_W;
  localparam int W  = bpcr_pkg::SQ_W;

  logic           v_q  [NS];
  logic           v_in [NS];
  logic [NS:0]    rdy;
  logic [W-1:0]   n_q  [NS][LANES];
  logic [W-1:0]   r_q  [NS][LANES];
  logic [W-1:0]   n_in [NS][LANES];
  logic [W-1:0]   r_in [NS][LANES];
  logic [W-1:0]   n_d  [NS][LANES];
  logic [W-1:0]   r_d  [NS][LANES];
  logic [SBW-1:0] sb_q  [NS];
  logic [SBW-1:0] sb_in [NS];

  // A stage may load when it is empty or its word moves on.
  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  // Stage inputs: the port for the first stage, the previous stage elsewhere.
  always_comb begin
    v_in[0]  = in_valid_i;
    sb_in[0] = in_side_i;
    for (int l = 0; l < LANES; l++) begin
      n_in[0][l] = in_rad_i[l];
      r_in[0][l] = '0;
    end
    for (int k = 1; k < NS; k++) begin
      v_in[k]  = v_q[k-1];
      sb_in[k] = sb_q[k-1];
      for (int l = 0; l < LANES; l++) begin
        n_in[k][l] = n_q[k-1][l];
        r_in[k][l] = r_q[k-1][l];
      end
    end
  end

  // One digit of the bitwise root per stage.
  always_comb begin
    logic [W-1:0] bitk;
    logic [W-1:0] trial;
    for (int k = 0; k < NS; k++) begin
      bitk = W'(1) << (2 * (NS - 1 - k));
      for (int l = 0; l < LANES; l++) begin
        trial = r_in[k][l] + bitk;
        if (n_in[k][l] >= trial) begin
          n_d[k][l] = n_in[k][l] - trial;
          r_d[k][l] = (r_in[k][l] >> 1) + bitk;
        end else begin
          n_d[k][l] = n_in[k][l];
          r_d[k][l] = r_in[k][l] >> 1;
        end
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) v_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_in[k];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k] && v_in[k]) begin
        sb_q[k] <= sb_in[k];
        for (int l = 0; l < LANES; l++) begin
          n_q[k][l] <= n_d[k][l];
          r_q[k][l] <= r_d[k][l];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign out_side_o  = sb_q[NS-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_root_o[l] = r_q[NS-1][l][bpcr_pkg::ROOT_W-1:0];
    end
  end

endmodule

// ----- design/bpcr_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage over several lanes, with a sideband word and
// a per-stage valid that collapses bubbles under backpressure.
// ----------------------------------------------------------------------------
module bpcr_div #(
  parameter int LANES = 4,
  parameter int CW    = 48,
  parameter int DW    = 32,
  parameter int QW    = 17,
  parameter int SBW   = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [CW-1:0]  in_num_i [LANES],
  input  logic [DW-1:0]  in_dvs_i [LANES],
  input  logic [SBW-1:0] in_side_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [QW-1:0]  out_quo_o [LANES],
  output logic [SBW-1:0] out_side_o
);

  localparam int NS = QW;

  logic           v_q  [NS];
  logic           v_in [NS];
  logic [NS:0]    rdy;
  logic [CW-1:0]  rem_q  [NS][LANES];
  logic [CW-1:0]  rem_in [NS][LANES];
  logic [CW-1:0]  rem_d  [NS][LANES];
  logic [DW-1:0]  dvs_q  [NS][LANES];
  logic [DW-1:0]  dvs_in [NS][LANES];
  logic [QW-1:0]  quo_q  [NS][LANES];
  logic [QW-1:0]  quo_in [NS][LANES];
  logic [QW-1:0]  quo_d  [NS][LANES];
  logic [SBW-1:0] sb_q  [NS];
  logic [SBW-1:0] sb_in [NS];

  // A stage may load when it is empty or its word moves on.
  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  // Stage inputs.
  always_comb begin
    v_in[0]  = in_valid_i;
    sb_in[0] = in_side_i;
    for (int l = 0; l < LANES; l++) begin
      rem_in[0][l] = in_num_i[l];
      dvs_in[0][l] = in_dvs_i[l];
      quo_in[0][l] = '0;
    end
    for (int k = 1; k < NS; k++) begin
      v_in[k]  = v_q[k-1];
      sb_in[k] = sb_q[k-1];
      for (int l = 0; l < LANES; l++) begin
        rem_in[k][l] = rem_q[k-1][l];
        dvs_in[k][l] = dvs_q[k-1][l];
        quo_in[k][l] = quo_q[k-1][l];
      end
    end
  end

  // Trial subtract of the shifted divisor, most significant bit first.
  always_comb begin
    logic [CW-1:0] trial;
    for (int k = 0; k < NS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        trial = CW'(dvs_in[k][l]) << (QW - 1 - k);
        if (rem_in[k][l] >= trial) begin
          rem_d[k][l] = rem_in[k][l] - trial;
          quo_d[k][l] = quo_in[k][l] | (QW'(1) << (QW - 1 - k));
        end else begin
          rem_d[k][l] = rem_in[k][l];
          quo_d[k][l] = quo_in[k][l];
        end
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) v_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_in[k];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k] && v_in[k]) begin
        sb_q[k] <= sb_in[k];
        for (int l = 0; l < LANES; l++) begin
          rem_q[k][l] <= rem_d[k][l];
          dvs_q[k][l] <= dvs_in[k][l];
          quo_q[k][l] <= quo_d[k][l];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign out_side_o  = sb_q[NS-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_quo_o[l] = quo_q[NS-1][l];
    end
  end

endmodule

// ----- design/ball_pair_collision_response.sv -----
// ----------------------------------------------------------------------------
// Ball pair collision response
// Equal-mass elastic response for one pair of circles per word.
// ----------------------------------------------------------------------------
// Pipeline: stages A to C, the 32-stage square root, the FRAC_BITS+1 stage
// divider, then stages D to G.
// Throughput: one word per cycle unless the output stalls; every stage holds
// its own valid bit, so a stalled output only holds back stages that are full.
// Reset: asynchronous, active low; it empties all pipeline stages.
module ball_pair_collision_response #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius, a_id,
  // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, b_id, zero pad
  input  logic [bpcr_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // new_vel_x, new_vel_y, msg_vel_x, msg_vel_y, new_pos_x, new_pos_y
  output logic [bpcr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // collided
  output logic                              m_axis_tuser_o
);

  localparam int LW    = FRAC_BITS + 2;           // signed unit component
  localparam int PW    = LW + bpcr_pkg::DV_W;     // unit times velocity difference
  localparam int SW    = PW + 1;                  // dot product sum
  localparam int U1W   = SW - FRAC_BITS;          // normal speed
  localparam int CDR_W = 35;                      // current distance minus radii
  localparam int UXW   = LW + U1W;
  localparam int SNW   = LW + CDR_W;
  localparam int CW    = bpcr_pkg::ROOT_W + FRAC_BITS;
  localparam int QW    = FRAC_BITS + 1;
  localparam int SIDE_W = $bits(bpcr_pkg::side_t);
  localparam int MID_W  = $bits(bpcr_pkg::mid_t);

  bpcr_pkg::in_word_t iw;
  assign iw = bpcr_pkg::in_word_t'(s_axis_tdata_i);

  // Stage handshake.
  logic va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_g;
  logic sq_in_ready, sq_out_valid, dv_in_ready, dv_out_valid;

  // Stage A: differences.
  bpcr_pkg::side_t    sa_side_d, sa_side_q;
  logic signed [33:0] sa_dx_q, sa_dy_q;
  logic signed [32:0] sa_cdx_q, sa_cdy_q;
  // Stage B: magnitudes and normalization.
  bpcr_pkg::side_t    sb_side_d, sb_side_q;
  logic [33:0]        mgx, mgy, mor;
  logic [32:0]        cmgx, cmgy, cmor;
  // Stage C: sums of squares.
  bpcr_pkg::side_t    sc_side_q;
  logic [bpcr_pkg::SQ_W-1:0] sc_n1_q, sc_n2_q;
  // Root and divide.
  logic [bpcr_pkg::SQ_W-1:0]   sq_rad  [2];
  logic [bpcr_pkg::ROOT_W-1:0] sq_root [2];
  logic [SIDE_W-1:0]           sq_side;
  bpcr_pkg::mid_t              mid_in, mid_out;
  logic [MID_W-1:0]            dv_side;
  logic [CW-1:0]               dv_num [4];
  logic [bpcr_pkg::ROOT_W-1:0] dv_dvs [4];
  logic [QW-1:0]               dv_quo [4];
  // Stage D: unit vectors and dot product terms.
  logic signed [LW-1:0]    lx_d, ly_d, cx_d, cy_d;
  logic [34:0]             d_len;
  logic [33:0]             cd_len;
  logic signed [CDR_W-1:0] cdr_d;
  logic                    hitpre_d;
  logic signed [PW-1:0]    sd_px_q, sd_py_q;
  logic signed [LW-1:0]    sd_lx_q, sd_ly_q, sd_cx_q, sd_cy_q;
  logic signed [CDR_W-1:0] sd_cdr_q;
  logic                    sd_hitpre_q, sd_cdnz_q;
  bpcr_pkg::side_t         sd_side_q;
  // Stage E: normal speed and decision.
  logic signed [SW-1:0]    dot_sum;
  logic signed [U1W-1:0]   u1_d, se_u1_q;
  logic signed [LW-1:0]    se_lx_q, se_ly_q, se_cx_q, se_cy_q;
  logic signed [CDR_W-1:0] se_cdr_q;
  logic                    se_hit_q, se_cdnz_q;
  bpcr_pkg::side_t         se_side_q;
  // Stage F: response products.
  logic signed [UXW-1:0]   sf_uxp_q, sf_uyp_q;
  logic signed [SNW-1:0]   sf_snx_q, sf_sny_q;
  logic                    sf_hit_q, sf_cdnz_q;
  bpcr_pkg::side_t         sf_side_q;
  // Stage G: output register.
  logic signed [63:0]      ux64, uy64, snx64, sny64;
  bpcr_pkg::out_word_t     ow_d, ow_q;
  logic                    col_q;

  // Ready chain from the output back to the input.
  assign rdy_g = !vg_q || m_axis_tready_i;
  assign rdy_f = !vf_q || rdy_g;
  assign rdy_e = !ve_q || rdy_f;
  assign rdy_d = !vd_q || rdy_e;
  assign rdy_c = !vc_q || sq_in_ready;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;
  assign s_axis_tready_o = rdy_a;

  // Stage A: velocity difference, radius sum and id compare.
  always_comb begin
    sa_side_d      = '0;
    sa_side_d.dvx  = 33'(iw.a_vel_x) - 33'(iw.b_vel_x);
    sa_side_d.dvy  = 33'(iw.a_vel_y) - 33'(iw.b_vel_y);
    sa_side_d.rsum = 32'(iw.a_radius) + 32'(iw.b_radius);
    sa_side_d.idne = iw.a_id != iw.b_id;
    sa_side_d.apx  = iw.a_pos_x;
    sa_side_d.apy  = iw.a_pos_y;
    sa_side_d.avx  = iw.a_vel_x;
    sa_side_d.avy  = iw.a_vel_y;
    sa_side_d.bvx  = iw.b_vel_x;
    sa_side_d.bvy  = iw.b_vel_y;
  end

  // Stage B: magnitudes, shifted until both fit in 31 bits.
  always_comb begin
    mgx  = sa_dx_q[33] ? 34'(-sa_dx_q) : 34'(sa_dx_q);
    mgy  = sa_dy_q[33] ? 34'(-sa_dy_q) : 34'(sa_dy_q);
    cmgx = sa_cdx_q[32] ? 33'(-sa_cdx_q) : 33'(sa_cdx_q);
    cmgy = sa_cdy_q[32] ? 33'(-sa_cdy_q) : 33'(sa_cdy_q);
    mor  = mgx | mgy;
    cmor = cmgx | cmgy;
    sb_side_d = sa_side_q;
    if (mor[33]) begin
      sb_side_d.s1 = 2'd3;
    end else if (mor[32]) begin
      sb_side_d.s1 = 2'd2;
    end else if (mor[31]) begin
      sb_side_d.s1 = 2'd1;
    end else begin
      sb_side_d.s1 = 2'd0;
    end
    if (cmor[32]) begin
      sb_side_d.s2 = 2'd2;
    end else if (cmor[31]) begin
      sb_side_d.s2 = 2'd1;
    end else begin
      sb_side_d.s2 = 2'd0;
    end
    sb_side_d.mx  = bpcr_pkg::MAG_W'(mgx >> sb_side_d.s1);
    sb_side_d.my  = bpcr_pkg::MAG_W'(mgy >> sb_side_d.s1);
    sb_side_d.cmx = bpcr_pkg::MAG_W'(cmgx >> sb_side_d.s2);
    sb_side_d.cmy = bpcr_pkg::MAG_W'(cmgy >> sb_side_d.s2);
    sb_side_d.nx  = sa_dx_q[33];
    sb_side_d.ny  = sa_dy_q[33];
    sb_side_d.cnx = sa_cdx_q[32];
    sb_side_d.cny = sa_cdy_q[32];
  end

  // Root over both distance vectors.
  assign sq_rad[0] = sc_n1_q;
  assign sq_rad[1] = sc_n2_q;

  bpcr_isqrt #(
    .LANES (2),
    .SBW   (SIDE_W)
  ) u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vc_q),
    .in_ready_o  (sq_in_ready),
    .in_rad_i    (sq_rad),
    .in_side_i   (sc_side_q),
    .out_valid_o (sq_out_valid),
    .out_ready_i (dv_in_ready),
    .out_root_o  (sq_root),
    .out_side_o  (sq_side)
  );

  // Component magnitudes scaled up and divided by the length.
  always_comb begin
    mid_in.side = bpcr_pkg::side_t'(sq_side);
    mid_in.q1   = sq_root[0];
    mid_in.q2   = sq_root[1];
    dv_num[0]   = CW'(mid_in.side.mx) << FRAC_BITS;
    dv_num[1]   = CW'(mid_in.side.my) << FRAC_BITS;
    dv_num[2]   = CW'(mid_in.side.cmx) << FRAC_BITS;
    dv_num[3]   = CW'(mid_in.side.cmy) << FRAC_BITS;
    dv_dvs[0]   = sq_root[0];
    dv_dvs[1]   = sq_root[0];
    dv_dvs[2]   = sq_root[1];
    dv_dvs[3]   = sq_root[1];
  end

  bpcr_div #(
    .LANES (4),
    .CW    (CW),
    .DW    (bpcr_pkg::ROOT_W),
    .QW    (QW),
    .SBW   (MID_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_out_valid),
    .in_ready_o  (dv_in_ready),
    .in_num_i    (dv_num),
    .in_dvs_i    (dv_dvs),
    .in_side_i   (mid_in),
    .out_valid_o (dv_out_valid),
    .out_ready_i (rdy_d),
    .out_quo_o   (dv_quo),
    .out_side_o  (dv_side)
  );

  // Stage D: signed unit vectors, lengths and the collision prerequisites.
  always_comb begin
    mid_out = bpcr_pkg::mid_t'(dv_side);
    if (mid_out.q1 == '0) begin
      lx_d = '0;
      ly_d = '0;
    end else begin
      lx_d = mid_out.side.nx ? -$signed(LW'(dv_quo[0])) : $signed(LW'(dv_quo[0]));
      ly_d = mid_out.side.ny ? -$signed(LW'(dv_quo[1])) : $signed(LW'(dv_quo[1]));
    end
    if (mid_out.q2 == '0) begin
      cx_d = '0;
      cy_d = '0;
    end else begin
      cx_d = mid_out.side.cnx ? -$signed(LW'(dv_quo[2])) : $signed(LW'(dv_quo[2]));
      cy_d = mid_out.side.cny ? -$signed(LW'(dv_quo[3])) : $signed(LW'(dv_quo[3]));
    end
    d_len    = 35'(mid_out.q1) << mid_out.side.s1;
    cd_len   = 34'(mid_out.q2) << mid_out.side.s2;
    hitpre_d = (mid_out.q1 != '0) && (d_len < 35'(mid_out.side.rsum)) && mid_out.side.idne;
    cdr_d    = $signed(35'(cd_len)) - $signed(35'(mid_out.side.rsum));
  end

  // Stage E: normal speed along the predicted unit vector.
  assign dot_sum = SW'(sd_px_q) + SW'(sd_py_q);
  assign u1_d    = U1W'(dot_sum >>> FRAC_BITS);

  // Stage G: velocity exchange, position snap and saturation.
  always_comb begin
    ux64  = 64'(sf_uxp_q >>> FRAC_BITS);
    uy64  = 64'(sf_uyp_q >>> FRAC_BITS);
    snx64 = 64'(sf_snx_q >>> FRAC_BITS);
    sny64 = 64'(sf_sny_q >>> FRAC_BITS);
    ow_d.new_vel_x = sf_side_q.avx;
    ow_d.new_vel_y = sf_side_q.avy;
    ow_d.msg_vel_x = sf_side_q.bvx;
    ow_d.msg_vel_y = sf_side_q.bvy;
    ow_d.new_pos_x = sf_side_q.apx;
    ow_d.new_pos_y = sf_side_q.apy;
    if (sf_hit_q) begin
      ow_d.new_vel_x = bpcr_pkg::sat32(64'(sf_side_q.avx) - ux64);
      ow_d.new_vel_y = bpcr_pkg::sat32(64'(sf_side_q.avy) - uy64);
      ow_d.msg_vel_x = bpcr_pkg::sat32(64'(sf_side_q.bvx) + ux64);
      ow_d.msg_vel_y = bpcr_pkg::sat32(64'(sf_side_q.bvy) + uy64);
      if (sf_cdnz_q) begin
        ow_d.new_pos_x = bpcr_pkg::sat32(64'(sf_side_q.apx) - snx64);
        ow_d.new_pos_y = bpcr_pkg::sat32(64'(sf_side_q.apy) - sny64);
      end
    end
  end

  // Valid bits of the top-level stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= s_axis_tvalid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= dv_out_valid;
      if (rdy_e) ve_q <= vd_q;
      if (rdy_f) vf_q <= ve_q;
      if (rdy_g) vg_q <= vf_q;
    end
  end

  // Payload registers of the top-level stages.
  always_ff @(posedge clk_i) begin
    if (rdy_a && s_axis_tvalid_i) begin
      sa_side_q <= sa_side_d;
      sa_dx_q   <= (34'(iw.a_pos_x) + 34'(iw.a_vel_x)) - (34'(iw.b_pos_x) + 34'(iw.b_vel_x));
      sa_dy_q   <= (34'(iw.a_pos_y) + 34'(iw.a_vel_y)) - (34'(iw.b_pos_y) + 34'(iw.b_vel_y));
      sa_cdx_q  <= 33'(iw.a_pos_x) - 33'(iw.b_pos_x);
      sa_cdy_q  <= 33'(iw.a_pos_y) - 33'(iw.b_pos_y);
    end
    if (rdy_b && va_q) begin
      sb_side_q <= sb_side_d;
    end
    if (rdy_c && vb_q) begin
      sc_side_q <= sb_side_q;
      sc_n1_q   <= bpcr_pkg::SQ_W'(sb_side_q.mx) * bpcr_pkg::SQ_W'(sb_side_q.mx)
                 + bpcr_pkg::SQ_W'(sb_side_q.my) * bpcr_pkg::SQ_W'(sb_side_q.my);
      sc_n2_q   <= bpcr_pkg::SQ_W'(sb_side_q.cmx) * bpcr_pkg::SQ_W'(sb_side_q.cmx)
                 + bpcr_pkg::SQ_W'(sb_side_q.cmy) * bpcr_pkg::SQ_W'(sb_side_q.cmy);
    end
    if (rdy_d && dv_out_valid) begin
      sd_px_q     <= lx_d * mid_out.side.dvx;
      sd_py_q     <= ly_d * mid_out.side.dvy;
      sd_lx_q     <= lx_d;
      sd_ly_q     <= ly_d;
      sd_cx_q     <= cx_d;
      sd_cy_q     <= cy_d;
      sd_cdr_q    <= cdr_d;
      sd_hitpre_q <= hitpre_d;
      sd_cdnz_q   <= mid_out.q2 != '0;
      sd_side_q   <= mid_out.side;
    end
    if (rdy_e && vd_q) begin
      se_u1_q   <= u1_d;
      se_hit_q  <= sd_hitpre_q && u1_d[U1W-1];
      se_lx_q   <= sd_lx_q;
      se_ly_q   <= sd_ly_q;
      se_cx_q   <= sd_cx_q;
      se_cy_q   <= sd_cy_q;
      se_cdr_q  <= sd_cdr_q;
      se_cdnz_q <= sd_cdnz_q;
      se_side_q <= sd_side_q;
    end
    if (rdy_f && ve_q) begin
      sf_uxp_q  <= se_lx_q * se_u1_q;
      sf_uyp_q  <= se_ly_q * se_u1_q;
      sf_snx_q  <= se_cx_q * se_cdr_q;
      sf_sny_q  <= se_cy_q * se_cdr_q;
      sf_hit_q  <= se_hit_q;
      sf_cdnz_q <= se_cdnz_q;
      sf_side_q <= se_side_q;
    end
    if (rdy_g && vf_q) begin
      ow_q  <= ow_d;
      col_q <= sf_hit_q;
    end
  end

  assign m_axis_tvalid_o = vg_q;
  assign m_axis_tdata_o  = ow_q;
  assign m_axis_tuser_o  = col_q;

endmodule

// ----- design/bpcr_chk.sv -----
// ----------------------------------------------------------------------------
// Ball pair collision response: port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module bpcr_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [bpcr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input logic                              m_axis_tuser_o
);

  // A stalled output word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its data and flag.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output word changed while stalled");

  // The input only waits when a finished word is held at the output.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled while the output was free");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid right after reset");

endmodule

bind ball_pair_collision_response bpcr_chk u_bpcr_chk (.*);

// ----- bench/ball_pair_collision_response_tb.sv -----
// ----------------------------------------------------------------------------
// Ball pair collision response testbench
// Streams circle pairs into the block under random sender gaps and receiver
// stalls, predicts each response word in fixed point and checks every field.
// ----------------------------------------------------------------------------

// Expected response words, kept in arrival order.
class collision_scoreboard;
  typedef struct packed {
    logic             collided;
    bpcr_pkg::out_word_t w;
  } resp_t;

  resp_t pending[$];
  int    errors;

  // Floor division by 2^16 of a wide signed value.
  static function logic signed [127:0] fdiv(logic signed [127:0] v);
    return v >>> 16;
  endfunction

  // Length and unit vector of a difference vector, normalized first.
  static function void vec_measure(input logic signed [63:0] dx,
      input logic signed [63:0] dy, output logic signed [63:0] len,
      output logic signed [63:0] lx, output logic signed [63:0] ly);
    logic [63:0] mx, my, n, r, b;
    int s;
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    s = 0;
    while (mx >= 64'h8000_0000 || my >= 64'h8000_0000) begin
      mx = mx >> 1;
      my = my >> 1;
      s++;
    end
    n = mx * mx + my * my;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    len = r << s;
    if (r == 0) begin
      lx = 0;
      ly = 0;
    end else begin
      lx = (mx << 16) / r;
      ly = (my << 16) / r;
      if (dx < 0) lx = -lx;
      if (dy < 0) ly = -ly;
    end
  endfunction

  static function logic [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7fff_ffff;
    if (v < -128'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Note an accepted input word and queue its expected response.
  function void note_pair(bpcr_pkg::in_word_t p);
    logic signed [63:0] apx, apy, avx, avy, bpx, bpy, bvx, bvy, rsum;
    logic signed [63:0] d, lx, ly, cd, cx, cy;
    logic signed [127:0] u1, ux, uy, nvx, nvy, mvx, mvy, npx, npy;
    logic hit;
    resp_t r;
    apx = p.a_pos_x; apy = p.a_pos_y; avx = p.a_vel_x; avy = p.a_vel_y;
    bpx = p.b_pos_x; bpy = p.b_pos_y; bvx = p.b_vel_x; bvy = p.b_vel_y;
    rsum = $signed({33'd0, p.a_radius}) + $signed({33'd0, p.b_radius});
    nvx = avx; nvy = avy; mvx = bvx; mvy = bvy; npx = apx; npy = apy;
    vec_measure((apx + avx) - (bpx + bvx), (apy + avy) - (bpy + bvy), d, lx, ly);
    u1 = fdiv(128'(lx) * 128'(avx - bvx) + 128'(ly) * 128'(avy - bvy));
    hit = d > 0 && d < rsum && u1 < 0 && p.a_id != p.b_id;
    if (hit) begin
      ux = fdiv(128'(lx) * u1);
      uy = fdiv(128'(ly) * u1);
      nvx = avx - ux; nvy = avy - uy;
      mvx = bvx + ux; mvy = bvy + uy;
      vec_measure(apx - bpx, apy - bpy, cd, cx, cy);
      if (cd > 0) begin
        npx = apx - fdiv(128'(cx) * 128'(cd - rsum));
        npy = apy - fdiv(128'(cy) * 128'(cd - rsum));
      end
    end
    r.collided = hit;
    r.w.new_vel_x = clamp32(nvx); r.w.new_vel_y = clamp32(nvy);
    r.w.msg_vel_x = clamp32(mvx); r.w.msg_vel_y = clamp32(mvy);
    r.w.new_pos_x = clamp32(npx); r.w.new_pos_y = clamp32(npy);
    pending.push_back(r);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Check one accepted response word against the oldest expectation.
  task check_word(logic collided, bpcr_pkg::out_word_t w);
    resp_t e;
    if (pending.size() == 0) begin
      report("unexpected word", w.new_vel_x, 0);
      return;
    end
    e = pending.pop_front();
    if (collided !== e.collided) report("collided", collided, e.collided);
    if (w.new_vel_x !== e.w.new_vel_x) report("new_vel_x", w.new_vel_x, e.w.new_vel_x);
    if (w.new_vel_y !== e.w.new_vel_y) report("new_vel_y", w.new_vel_y, e.w.new_vel_y);
    if (w.msg_vel_x !== e.w.msg_vel_x) report("msg_vel_x", w.msg_vel_x, e.w.msg_vel_x);
    if (w.msg_vel_y !== e.w.msg_vel_y) report("msg_vel_y", w.msg_vel_y, e.w.msg_vel_y);
    if (w.new_pos_x !== e.w.new_pos_x) report("new_pos_x", w.new_pos_x, e.w.new_pos_x);
    if (w.new_pos_y !== e.w.new_pos_y) report("new_pos_y", w.new_pos_y, e.w.new_pos_y);
  endtask
endclass

module ball_pair_collision_response_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [bpcr_pkg::IN_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [bpcr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;

  collision_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_count = 0;

  always #5 clk_i = ~clk_i;

  ball_pair_collision_response uut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  // Receiver: random stalls, check every accepted word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_word(m_axis_tuser_o, bpcr_pkg::out_word_t'(m_axis_tdata_o));
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Drive one pair word, with a random gap before it, and wait for accept.
  // Valid stays high into the next word when there is no gap.
  task send_pair(bpcr_pkg::in_word_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= p;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_pair(p);
  endtask

  function automatic logic [31:0] rnd32();
    return $urandom();
  endfunction

  // Small coordinate around zero, a few balls apart (in Q16.16).
  function automatic logic [31:0] near(int span);
    return 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  // Mostly pairs close enough to touch; some wild noise.
  function automatic bpcr_pkg::in_word_t random_pair();
    bpcr_pkg::in_word_t p;
    int kind;
    kind = int'($urandom_range(9));
    p = '0;
    if (kind < 7) begin
      p.a_pos_x = near(32'h0006_0000); p.a_pos_y = near(32'h0006_0000);
      p.b_pos_x = near(32'h0006_0000); p.b_pos_y = near(32'h0006_0000);
      p.a_vel_x = near(32'h0002_0000); p.a_vel_y = near(32'h0002_0000);
      p.b_vel_x = near(32'h0002_0000); p.b_vel_y = near(32'h0002_0000);
      p.a_radius = 31'($urandom_range(32'h0006_0000));
      p.b_radius = 31'($urandom_range(32'h0006_0000));
      p.a_id = 8'($urandom());
      p.b_id = ($urandom_range(7) == 0) ? p.a_id : 8'($urandom());
    end else begin
      p.a_pos_x = rnd32(); p.a_pos_y = rnd32(); p.a_vel_x = rnd32(); p.a_vel_y = rnd32();
      p.b_pos_x = rnd32(); p.b_pos_y = rnd32(); p.b_vel_x = rnd32(); p.b_vel_y = rnd32();
      p.a_radius = 31'($urandom()); p.b_radius = 31'($urandom());
      p.a_id = 8'($urandom()); p.b_id = 8'($urandom());
    end
    return p;
  endfunction

  function automatic bpcr_pkg::in_word_t mk(int apx, int apy, int avx, int avy, int ar,
      int bpx, int bpy, int bvx, int bvy, int br, int aid, int bid);
    bpcr_pkg::in_word_t p;
    p = '0;
    p.a_pos_x = apx; p.a_pos_y = apy; p.a_vel_x = avx; p.a_vel_y = avy;
    p.a_radius = 31'(ar); p.a_id = 8'(aid);
    p.b_pos_x = bpx; p.b_pos_y = bpy; p.b_vel_x = bvx; p.b_vel_y = bvy;
    p.b_radius = 31'(br); p.b_id = 8'(bid);
    return p;
  endfunction

  localparam int ONE = 32'h0001_0000;
  localparam int MAXP = 32'h7fff_ffff;
  localparam int MINP = 32'h8000_0000;

  initial begin
    int n;
    bpcr_pkg::in_word_t p;
    int phase_pct[4][2];
    phase_pct = '{'{0, 0}, '{48, 0}, '{0, 48}, '{28, 28}};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: head-on hit, miss, equal ids, receding, coincident, extremes.
    send_pair(mk(0, 0, ONE, 0, ONE, 3 * ONE, 0, -ONE, 0, ONE, 1, 2));
    send_pair(mk(0, 0, ONE, ONE, ONE, 30 * ONE, 0, 0, 0, ONE, 1, 2));
    send_pair(mk(0, 0, ONE, 0, ONE, 3 * ONE, 0, -ONE, 0, ONE, 5, 5));
    send_pair(mk(0, 0, -ONE, 0, ONE, ONE, 0, ONE, 0, ONE, 1, 2));
    send_pair(mk(0, 0, ONE, ONE, ONE, 0, 0, ONE, ONE, ONE, 1, 2));
    send_pair(mk(0, 0, ONE, 0, 2 * ONE, 0, 0, -ONE, 0, 2 * ONE, 1, 2));
    send_pair(mk(ONE, ONE, 0, ONE, 2 * ONE, ONE, 3 * ONE, 0, -ONE, 2 * ONE, 0, 255));
    send_pair(mk(MAXP, MAXP, MAXP, MAXP, MAXP, MINP, MINP, MINP, MINP, MAXP, 255, 0));
    send_pair(mk(MINP, MINP, MINP, MINP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, 0, 1));
    send_pair(mk(MAXP, 0, MAXP, 0, MAXP, MAXP - 4 * ONE, 0, MINP, 0, MAXP, 3, 4));
    send_pair(mk(MINP, 0, MINP, 0, MAXP, MINP + 4 * ONE, 0, MAXP, 0, MAXP, 3, 4));
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk(-1, -1, -1, -1, MAXP, -1, -1, -1, -1, MAXP, 255, 255));
    send_pair(mk(0, 0, 0, 0, MAXP, 1, 0, 0, 0, 0, 170, 85));
    send_pair(mk(2 * ONE, -ONE, -ONE, ONE, ONE, 0, 0, ONE, -ONE, 3 * ONE, 85, 170));

    // Random part in four idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_pct[ph][0];
      recv_stall_pct = phase_pct[ph][1];
      n = (ph == 0) ? 200 : 210;
      for (int i = 0; i < n; i++) begin
        p = random_pair();
        send_pair(p);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
